// ===== design/tkdfc_pkg.sv =====
// shared types and constants for the two-key debounce fan control block
package tkdfc_pkg;

  // debounce scanner phases
  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_CHECK1 = 2'd1,
    SCAN_CHECK2 = 2'd2,
    SCAN_HOLD   = 2'd3
  } scan_phase_e;

  // confirmed key codes
  typedef enum logic [1:0] {
    KEY_NONE  = 2'd0,
    KEY_SPEED = 2'd1,
    KEY_RESET = 2'd2
  } key_code_e;

  // fan settings
  typedef enum logic [1:0] {
    FAN_STOP = 2'd0,
    FAN_LOW  = 2'd1,
    FAN_HIGH = 2'd2
  } fan_level_e;

  localparam int unsigned HoldW = 16;
  localparam logic [HoldW-1:0] LongPressReset = 16'd300;

  // register word indexes
  localparam logic [0:0] RegLongPress = 1'b0;

  // scanner status after one tick's scan
  typedef struct packed {
    key_code_e confirmed_key;
    logic      first_press;
    logic      long_press;
  } scan_t;

  // flag clears requested by the key actions
  typedef struct packed {
    logic first_press;
    logic long_press;
  } flag_clr_t;

  // one result item
  typedef struct packed {
    fan_level_e fan_level;
    logic       power_on;
    logic       anion_on;
    logic       gas_power_on;
    logic       lock_active;
    logic       filter_clear_pulse;
    key_code_e  key_code;
  } result_t;

endpackage

// ===== design/tkdfc_in_if.sv =====
// input channel: one scan tick per transfer
interface tkdfc_in_if;
  logic valid;
  logic ready;
  logic speed_key_low;
  logic reset_key_low;
  logic lock_request;

  modport source (output valid, output speed_key_low, output reset_key_low,
                  output lock_request, input ready);
  modport sink (input valid, input speed_key_low, input reset_key_low,
                input lock_request, output ready);
endinterface

// ===== design/tkdfc_out_if.sv =====
// output channel: control status after each scan tick
interface tkdfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] fan_level;
  logic       power_on;
  logic       anion_on;
  logic       gas_power_on;
  logic       lock_active;
  logic       filter_clear_pulse;
  logic [1:0] key_code;

  modport source (output valid, output fan_level, output power_on, output anion_on,
                  output gas_power_on, output lock_active, output filter_clear_pulse,
                  output key_code, input ready);
  modport sink (input valid, input fan_level, input power_on, input anion_on,
                input gas_power_on, input lock_active, input filter_clear_pulse,
                input key_code, output ready);
endinterface

// ===== design/tkdfc_scan.sv =====
// key debounce scanner with hold counter and long-press flag
module tkdfc_scan
  import tkdfc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic             speed_key_low_i,
  input  logic             reset_key_low_i,
  input  logic [HoldW-1:0] long_press_ticks_i,
  input  flag_clr_t        clr_i,
  output scan_t            scan_o
);

  scan_phase_e      phase_q, phase_d;
  logic             key_idx_q, key_idx_d;
  logic [HoldW-1:0] hold_q, hold_d, hold_inc;
  logic             first_q, first_d;
  logic             long_q, long_d;
  key_code_e        ckey_q, ckey_d;
  logic             sel_low;

  // pressed state of the key being tracked (inputs are active low), high means pressed
  assign sel_low  = key_idx_q ? ~reset_key_low_i : ~speed_key_low_i;
  assign hold_inc = hold_q + 16'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    case (phase_q)
      SCAN_IDLE: begin
        if (!speed_key_low_i || !reset_key_low_i) phase_d = SCAN_CHECK1;
      end
      SCAN_CHECK1: phase_d = sel_low ? SCAN_CHECK2 : SCAN_IDLE;
      SCAN_CHECK2: phase_d = sel_low ? SCAN_HOLD : SCAN_IDLE;
      SCAN_HOLD: begin
        if (!sel_low) phase_d = SCAN_IDLE;
      end
      default: phase_d = SCAN_IDLE;
    endcase
  end

  // key index, key code, hold counter and flags
  always_comb begin
    key_idx_d = key_idx_q;
    hold_d    = hold_q;
    first_d   = first_q;
    long_d    = long_q;
    ckey_d    = ckey_q;
    case (phase_q)
      SCAN_IDLE: begin
        if (!speed_key_low_i) begin
          key_idx_d = 1'b0;
        end else begin
          ckey_d = KEY_NONE;
          if (!reset_key_low_i) key_idx_d = 1'b1;
        end
      end
      SCAN_CHECK1: begin
        if (!sel_low) ckey_d = KEY_NONE;
      end
      SCAN_CHECK2: begin
        if (sel_low) begin
          ckey_d  = key_idx_q ? KEY_RESET : KEY_SPEED;
          first_d = 1'b1;
        end else begin
          ckey_d = KEY_NONE;
        end
      end
      SCAN_HOLD: begin
        first_d = 1'b0;
        if (!sel_low) begin
          long_d = 1'b0;
          hold_d = '0;
        end else if (hold_inc >= long_press_ticks_i) begin
          hold_d = '0;
          long_d = 1'b1;
        end else begin
          hold_d = hold_inc;
        end
      end
      default: ;
    endcase
  end

  assign scan_o = '{confirmed_key: ckey_d, first_press: first_d, long_press: long_d};

  // state update once per accepted tick, action clears applied last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= SCAN_IDLE;
      key_idx_q <= 1'b0;
      hold_q    <= '0;
      first_q   <= 1'b0;
      long_q    <= 1'b0;
      ckey_q    <= KEY_NONE;
    end else if (step_i) begin
      phase_q   <= phase_d;
      key_idx_q <= key_idx_d;
      hold_q    <= hold_d;
      first_q   <= first_d & ~clr_i.first_press;
      long_q    <= long_d & ~clr_i.long_press;
      ckey_q    <= ckey_d;
    end
  end

endmodule

// ===== design/tkdfc_action.sv =====
// key actions: fan, power, anion, gas drive and filter lock
module tkdfc_action
  import tkdfc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  logic      lock_request_i,
  input  scan_t     scan_i,
  output flag_clr_t clr_o,
  output result_t   res_o
);

  fan_level_e fan_q, fan_d;
  logic       power_q, power_d;
  logic       anion_q, anion_d;
  logic       gas_q, gas_d;
  logic       locked_q, locked_d;
  logic       pulse;

  // actions of the confirmed key, lock request applied first
  always_comb begin
    fan_d    = fan_q;
    power_d  = power_q;
    anion_d  = anion_q;
    gas_d    = gas_q;
    locked_d = locked_q | lock_request_i;
    pulse    = 1'b0;
    clr_o    = '0;
    case (scan_i.confirmed_key)
      KEY_SPEED: begin
        if (!locked_d) begin
          if (scan_i.first_press) begin
            clr_o.first_press = 1'b1;
            gas_d   = 1'b1;
            fan_d   = (fan_q != FAN_HIGH) ? FAN_HIGH : FAN_LOW;
            anion_d = 1'b1;
            power_d = 1'b1;
          end else if (scan_i.long_press) begin
            clr_o.long_press = 1'b1;
            power_d = 1'b0;
            fan_d   = FAN_STOP;
            anion_d = 1'b0;
          end
        end
      end
      KEY_RESET: begin
        if (scan_i.long_press) begin
          clr_o.long_press = 1'b1;
          if (locked_d) begin
            locked_d = 1'b0;
            pulse    = 1'b1;
            power_d  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  assign res_o = '{fan_level: fan_d, power_on: power_d, anion_on: anion_d,
                   gas_power_on: gas_d, lock_active: locked_d,
                   filter_clear_pulse: pulse, key_code: scan_i.confirmed_key};

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_q    <= FAN_STOP;
      power_q  <= 1'b0;
      anion_q  <= 1'b0;
      gas_q    <= 1'b0;
      locked_q <= 1'b0;
    end else if (step_i) begin
      fan_q    <= fan_d;
      power_q  <= power_d;
      anion_q  <= anion_d;
      gas_q    <= gas_d;
      locked_q <= locked_d;
    end
  end

endmodule

// ===== design/two_key_debounce_fan_control.sv =====
// top level: input register, scanner, key actions and result register
//
//   channel   dir   handshake          payload
//   in_i      in    valid / ready      speed_key_low, reset_key_low, lock_request
//   out_o     out   valid / ready      fan_level .. key_code, one per tick
//   apb       in    psel/penable/...   long_press_ticks, read at address 0, written at any
//
// one tick per cycle while the output is not stalled; a tick is held in the input
// register, then its result in the result register until out_o takes it
// the scan and action update sits between the input and result registers
// a stalled output holds the pipe; the input register still takes one tick
// reset clears all scan and control state and loads long_press_ticks = 300
module two_key_debounce_fan_control
  import tkdfc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tkdfc_in_if.sink    in_i,
  tkdfc_out_if.source out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic             in_valid_q;
  logic             spd_q, rst_key_q, lock_q;
  logic             out_valid_q;
  result_t          res_q, res_d;
  logic             advance;
  logic [HoldW-1:0] lpt_q;
  scan_t            scan;
  flag_clr_t        clr;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[1:0] == 2'd0) ? {16'd0, lpt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lpt_q <= LongPressReset;
    end else if (psel && penable && pwrite && pready) begin
      lpt_q <= pwdata[HoldW-1:0];
    end
  end

  // pipeline control
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) in_valid_q <= in_i.valid;
      if (advance) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      spd_q     <= in_i.speed_key_low;
      rst_key_q <= in_i.reset_key_low;
      lock_q    <= in_i.lock_request;
    end
  end

  tkdfc_scan u_scan (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (advance),
    .speed_key_low_i    (spd_q),
    .reset_key_low_i    (rst_key_q),
    .long_press_ticks_i (lpt_q),
    .clr_i              (clr),
    .scan_o             (scan)
  );

  tkdfc_action u_action (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .lock_request_i (lock_q),
    .scan_i         (scan),
    .clr_o          (clr),
    .res_o          (res_d)
  );

  // result register
  always_ff @(posedge clk_i) begin
    if (advance) res_q <= res_d;
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.fan_level          = res_q.fan_level;
  assign out_o.power_on           = res_q.power_on;
  assign out_o.anion_on           = res_q.anion_on;
  assign out_o.gas_power_on       = res_q.gas_power_on;
  assign out_o.lock_active        = res_q.lock_active;
  assign out_o.filter_clear_pulse = res_q.filter_clear_pulse;
  assign out_o.key_code           = res_q.key_code;

`ifndef SYNTHESIS
  // a filter clear always comes with the unlock
  a_clear_unlocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.filter_clear_pulse |-> !out_o.lock_active)
    else $error("filter clear while still locked");

  // anion is only switched on together with the latched gas drive
  a_anion_gas: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.anion_on |-> out_o.gas_power_on)
    else $error("anion on without gas drive");

  // an empty result register never blocks the input
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_i.ready)
    else $error("input stalled with empty result register");
`endif

endmodule
